// ----- rtl/bol_pkg.sv -----
// Shared types and constants for the bounded ordered list.
package bol_pkg;

	localparam int CAPACITY_DEF = 16;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_REAR  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_REAR  = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_DEL_VALUE = 3'd6,
		OP_READ      = 3'd7
	} bol_op_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_RANGE   = 3'd3,
		ST_MISSING = 3'd4
	} bol_status_t;

	typedef struct packed {
		bol_op_t            operation;
		logic signed [31:0] value;
		logic [4:0]         position;
	} bol_in_t;

	typedef struct packed {
		bol_status_t        status;
		logic [4:0]         fill_after;
		logic signed [31:0] read_value;
		logic [3:0]         found_index;
	} bol_out_t;

endpackage

// ----- rtl/bounded_ordered_list_top.sv -----
// Each transaction is decoded first, then entries are moved one at a time through the entry memory.
// Inserts shift entries up and then place the new value; position deletes shift entries down;
// delete by value scans for the first match and then shifts down; a read fetches one entry;
// every result then passes through the output register.
// Throughput: one transaction in flight; a new one is taken while a result waits in the output.
// Reset clears the fill count and control state; the entry storage is not cleared.
module bounded_ordered_list_top import bol_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  bol_in_t  cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output bol_out_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic               idle;
	logic               res_valid;
	logic               res_ready;
	bol_out_t           res;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic signed [31:0] rd_data;
	logic               rsp_valid_q;
	bol_out_t           rsp_q;

	assign cmd_stall = !idle;
	assign res_ready = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	bol_ctrl #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.idle(idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	bol_mem #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (res_valid && res_ready) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= res;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("Controller took a transaction without going busy.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("Pending result changed while the output register was full.");

	a_failed_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_DONE |-> rsp.read_value == 0 && rsp.found_index == 0)
		else $error("Failed operation reported a read value or found index.");

endmodule

// ----- rtl/bol_mem.sv -----
// Entry storage with one write port and one registered read port.
module bol_mem import bol_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW = $clog2(CAPACITY_DEF)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic signed [31:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic signed [31:0] rd_data
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/bol_ctrl.sv -----
// Sequencer that decodes each operation and drives shifts and searches through the memory.
module bol_ctrl import bol_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int AW = $clog2(CAPACITY_DEF),
	parameter int CW = $clog2(CAPACITY_DEF + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  bol_in_t            cmd,
	output logic               idle,
	output logic               res_valid,
	input  logic               res_ready,
	output bol_out_t           res,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic signed [31:0] wr_data,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic signed [31:0] rd_data
);

	localparam int XW = (CW > 5) ? CW : 5;

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_UP, S_PLACE, S_DOWN, S_SCAN, S_RDWAIT, S_RESULT
	} state_t;

	state_t             state_q;
	bol_op_t            op_q;
	logic signed [31:0] value_q;
	logic [4:0]         pos_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      at_q;
	logic               pw_q;
	logic [AW-1:0]      pw_addr_q;
	logic               cmp_v_q;
	logic [AW-1:0]      cmp_idx_q;
	bol_status_t        status_q;
	logic signed [31:0] rd_q;
	logic [AW-1:0]      found_q;
	logic               match;
	logic               empty;
	logic               pos_past_end;

	assign match = (rd_data == value_q);
	assign empty = (fill_q == '0);
	assign pos_past_end = (XW'(pos_q) >= XW'(fill_q));
	assign idle = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT);

	always_comb begin
		res.status = status_q;
		res.fill_after = 5'(fill_q);
		res.read_value = rd_q;
		res.found_index = 4'(found_q);
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = pw_addr_q;
		wr_data = rd_data;
		if (pw_q) begin
			wr_en = 1'b1;
		end else if (state_q == S_PLACE) begin
			wr_en = 1'b1;
			wr_addr = AW'(at_q);
			wr_data = value_q;
		end
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_DECIDE: begin
				if (op_q == OP_READ && !empty && !pos_past_end) begin
					rd_en = 1'b1;
					rd_addr = AW'(pos_q);
				end
			end
			S_UP: begin
				if (k_q > at_q) begin
					rd_en = 1'b1;
					rd_addr = AW'(k_q - 1'b1);
				end
			end
			S_DOWN: begin
				if ((k_q + 1'b1) < fill_q) begin
					rd_en = 1'b1;
					rd_addr = AW'(k_q + 1'b1);
				end
			end
			S_SCAN: begin
				if (!(cmp_v_q && match) && k_q < fill_q) begin
					rd_en = 1'b1;
					rd_addr = AW'(k_q);
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_READ;
			value_q <= '0;
			pos_q <= '0;
			fill_q <= '0;
			k_q <= '0;
			at_q <= '0;
			pw_q <= 1'b0;
			pw_addr_q <= '0;
			cmp_v_q <= 1'b0;
			cmp_idx_q <= '0;
			status_q <= ST_DONE;
			rd_q <= '0;
			found_q <= '0;
		end else begin
			pw_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q <= cmd.operation;
						value_q <= cmd.value;
						pos_q <= cmd.position;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					status_q <= ST_DONE;
					rd_q <= '0;
					found_q <= '0;
					k_q <= '0;
					cmp_v_q <= 1'b0;
					state_q <= S_RESULT;
					case (op_q)
						OP_INS_FRONT, OP_INS_REAR, OP_INS_AT: begin
							k_q <= fill_q;
							if (fill_q == CW'(CAPACITY)) begin
								status_q <= ST_FULL;
							end else if (op_q == OP_INS_FRONT) begin
								at_q <= '0;
								state_q <= S_UP;
							end else if (op_q == OP_INS_REAR) begin
								at_q <= fill_q;
								state_q <= S_UP;
							end else if (XW'(pos_q) > XW'(fill_q)) begin
								status_q <= ST_RANGE;
							end else begin
								at_q <= CW'(pos_q);
								state_q <= S_UP;
							end
						end
						OP_DEL_FRONT: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_DOWN;
							end
						end
						OP_DEL_REAR: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								fill_q <= fill_q - 1'b1;
							end
						end
						OP_DEL_AT: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else if (pos_past_end) begin
								status_q <= ST_RANGE;
							end else begin
								k_q <= CW'(pos_q);
								state_q <= S_DOWN;
							end
						end
						OP_DEL_VALUE: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else if (pos_past_end) begin
								status_q <= ST_RANGE;
							end else begin
								state_q <= S_RDWAIT;
							end
						end
					endcase
				end
				S_UP: begin
					pw_q <= rd_en;
					pw_addr_q <= AW'(k_q);
					if (rd_en) begin
						k_q <= k_q - 1'b1;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					fill_q <= fill_q + 1'b1;
					state_q <= S_RESULT;
				end
				S_DOWN: begin
					pw_q <= rd_en;
					pw_addr_q <= AW'(k_q);
					if (rd_en) begin
						k_q <= k_q + 1'b1;
					end else begin
						fill_q <= fill_q - 1'b1;
						state_q <= S_RESULT;
					end
				end
				S_SCAN: begin
					if (cmp_v_q && match) begin
						found_q <= cmp_idx_q;
						k_q <= CW'(cmp_idx_q);
						cmp_v_q <= 1'b0;
						state_q <= S_DOWN;
					end else if (rd_en) begin
						cmp_v_q <= 1'b1;
						cmp_idx_q <= AW'(k_q);
						k_q <= k_q + 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
						status_q <= ST_MISSING;
						state_q <= S_RESULT;
					end
				end
				S_RDWAIT: begin
					rd_q <= rd_data;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- verif/bol_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the bounded ordered list: mirrors the list contents and checks every response.
module bol_checker import bol_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  logic     cmd_stall,
	input  bol_in_t  cmd,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  bol_out_t rsp,
	output int       mismatches,
	output int       pending
);

	logic signed [31:0] list_entries [CAPACITY];
	int                 list_fill;
	bol_out_t           awaited_rsp [$];
	bol_out_t           want;

	function automatic void open_slot(int at, logic signed [31:0] v);
		for (int k = list_fill; k > at; k--)
			list_entries[k] = list_entries[k - 1];
		list_entries[at] = v;
		list_fill++;
	endfunction

	function automatic void close_slot(int at);
		for (int k = at; k + 1 < list_fill; k++)
			list_entries[k] = list_entries[k + 1];
		list_fill--;
	endfunction

	function automatic bol_out_t apply_list_op(bol_in_t c);
		bol_out_t r;
		int       hit;
		r = '0;
		r.status = ST_DONE;
		hit = -1;
		case (c.operation)
			OP_INS_FRONT, OP_INS_REAR, OP_INS_AT: begin
				if (list_fill >= CAPACITY)
					r.status = ST_FULL;
				else if (c.operation == OP_INS_FRONT)
					open_slot(0, c.value);
				else if (c.operation == OP_INS_REAR)
					open_slot(list_fill, c.value);
				else if (int'(c.position) > list_fill)
					r.status = ST_RANGE;
				else
					open_slot(int'(c.position), c.value);
			end
			OP_DEL_FRONT, OP_DEL_REAR: begin
				if (list_fill == 0)
					r.status = ST_EMPTY;
				else if (c.operation == OP_DEL_FRONT)
					close_slot(0);
				else
					list_fill--;
			end
			OP_DEL_AT: begin
				if (list_fill == 0)
					r.status = ST_EMPTY;
				else if (int'(c.position) >= list_fill)
					r.status = ST_RANGE;
				else
					close_slot(int'(c.position));
			end
			OP_DEL_VALUE: begin
				if (list_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int k = 0; k < list_fill; k++)
						if (hit < 0 && list_entries[k] == c.value)
							hit = k;
					if (hit < 0) begin
						r.status = ST_MISSING;
					end else begin
						r.found_index = 4'(hit);
						close_slot(hit);
					end
				end
			end
			default: begin
				if (list_fill == 0)
					r.status = ST_EMPTY;
				else if (int'(c.position) >= list_fill)
					r.status = ST_RANGE;
				else
					r.read_value = list_entries[int'(c.position)];
			end
		endcase
		r.fill_after = 5'(list_fill);
		return r;
	endfunction

	initial begin
		mismatches = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_fill = 0;
			awaited_rsp.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("bol_checker: response with none expected: status %0d fill %0d",
							rsp.status, rsp.fill_after);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status || rsp.fill_after !== want.fill_after ||
						rsp.read_value !== want.read_value ||
						rsp.found_index !== want.found_index) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("bol_checker: mismatch: expected status %0d fill %0d read %0d found %0d",
								want.status, want.fill_after, want.read_value, want.found_index);
							$display("bol_checker:           got status %0d fill %0d read %0d found %0d",
								rsp.status, rsp.fill_after, rsp.read_value, rsp.found_index);
						end
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				awaited_rsp.push_back(apply_list_op(cmd));
		end
		pending = awaited_rsp.size();
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the bounded ordered list: clock, reset, stimulus and final verdict.
module tb;
	import bol_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 650;
	localparam int BURST_LEN    = 40;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	bol_in_t  cmd = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	bol_out_t rsp;
	int       mismatches;
	int       pending;
	int       snd_idle_pct = 13;
	int       rcv_idle_pct = 61;
	int       cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bounded_ordered_list_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	bol_checker list_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic send_cmd(bol_op_t op, logic signed [31:0] v, logic [4:0] p);
		bol_in_t item;
		item.operation = op;
		item.value = v;
		item.position = p;
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic send_random(int insert_pct);
		int                 pick;
		bol_op_t            op;
		logic signed [31:0] v;
		logic [4:0]         p;
		pick = $urandom_range(99);
		if (pick < insert_pct)
			op = bol_op_t'(3'($urandom_range(OP_INS_AT, OP_INS_FRONT)));
		else if (pick < insert_pct + 15)
			op = OP_READ;
		else
			op = bol_op_t'(3'($urandom_range(OP_DEL_VALUE, OP_DEL_FRONT)));
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom_range(6) - 3;
			4: v = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: v = $urandom();
		endcase
		p = $urandom_range(1) ? 5'($urandom_range(16)) : 5'($urandom_range(3));
		send_cmd(op, v, p);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every removal and the read on an empty list, then an insert past the end.
		send_cmd(OP_DEL_FRONT, 32'd0, 5'd0);
		send_cmd(OP_DEL_REAR, 32'd0, 5'd0);
		send_cmd(OP_DEL_AT, 32'd0, 5'd0);
		send_cmd(OP_DEL_VALUE, 32'd0, 5'd0);
		send_cmd(OP_READ, 32'd0, 5'd0);
		send_cmd(OP_INS_AT, 32'd7, 5'd1);
		// Build min, 5, max, 5 and probe the range checks.
		send_cmd(OP_INS_FRONT, 32'h80000000, 5'd0);
		send_cmd(OP_INS_REAR, 32'h7fffffff, 5'd0);
		send_cmd(OP_INS_AT, 32'd5, 5'd1);
		send_cmd(OP_INS_AT, 32'd5, 5'd3);
		send_cmd(OP_INS_AT, 32'd1, 5'd16);
		send_cmd(OP_READ, 32'd0, 5'd0);
		send_cmd(OP_READ, 32'd0, 5'd3);
		send_cmd(OP_READ, 32'd0, 5'd16);
		send_cmd(OP_DEL_AT, 32'd0, 5'd4);
		send_cmd(OP_DEL_VALUE, 32'd9, 5'd0);
		// Duplicate fives: only the first one goes.
		send_cmd(OP_DEL_VALUE, 32'd5, 5'd0);
		send_cmd(OP_DEL_AT, 32'd0, 5'd1);
		send_cmd(OP_DEL_REAR, 32'd0, 5'd0);
		send_cmd(OP_INS_AT, 32'hffffffff, 5'd0);
		send_cmd(OP_DEL_FRONT, 32'd0, 5'd0);
		send_cmd(OP_DEL_VALUE, 32'h80000000, 5'd0);
		send_cmd(OP_READ, 32'd0, 5'd15);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				snd_idle_pct = 61;
				rcv_idle_pct = 13;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			send_random(((n / BURST_LEN) % 2 == 0) ? 70 : 20);
		end
		cmd_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bol_pkg.sv
rtl/bol_mem.sv
rtl/bol_ctrl.sv
rtl/bounded_ordered_list_top.sv
verif/bol_checker.sv
verif/tb.sv
